### hdl/bsts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsts_pkg: shared types, codes and control store for the best size table
// Word layouts of both channels, register indexes, item kinds and the
// microcode program that sequences init, update, lookup and flag items.
// ----------------------------------------------------------------------------
package bsts_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 1024;
    localparam int PARAM_COUNT         = 5;
    localparam int PARAM_W             = 16;
    localparam int SIZE_W              = 64;
    localparam int ROW_W               = 10;
    localparam int CID_W               = 6;
    localparam int AUX_W               = CID_W + PARAM_COUNT * PARAM_W;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 64;
    localparam int ENTRY_RESET         = 1023;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_CAP    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 2'd1;

    // item kinds
    localparam logic [1:0] KIND_INIT   = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;
    localparam logic [1:0] KIND_FLAG   = 2'd3;

    typedef struct packed {
        logic [1:0]                kind;
        logic [ROW_W-1:0]          row;
        logic [SIZE_W-1:0]         size_value;
        logic [CID_W-1:0]          construction_id;
        logic signed [PARAM_W-1:0] param_a;
        logic signed [PARAM_W-1:0] param_b;
        logic signed [PARAM_W-1:0] param_c;
        logic signed [PARAM_W-1:0] param_d;
        logic signed [PARAM_W-1:0] param_e;
    } bsts_in_t;

    typedef struct packed {
        logic [ROW_W-1:0] found_index;
        logic             not_found;
        logic             accepted;
        logic             changed_flag;
    } bsts_out_t;

    // datapath operation selected by a control word
    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_INIT_REGS,
        OP_FILL,
        OP_EMIT,
        OP_UPD_READ,
        OP_UPD_DECIDE,
        OP_FLAG_CLR,
        OP_LK_INIT,
        OP_LK_LAST,
        OP_LK_MID,
        OP_LK_CMP
    } op_t;

    // branch condition selected by a control word
    typedef enum logic [3:0] {
        JC_ALWAYS,
        JC_DISPATCH,
        JC_FILL_MORE,
        JC_OUT_READY,
        JC_EMPTY,
        JC_LAST_LOW,
        JC_RANGE_DONE,
        JC_HIT
    } jc_t;

    typedef logic [3:0] step_t;

    localparam step_t S_IDLE       = 4'd0;
    localparam step_t S_INIT       = 4'd1;
    localparam step_t S_FILL       = 4'd2;
    localparam step_t S_EMIT       = 4'd3;
    localparam step_t S_UPD_READ   = 4'd4;
    localparam step_t S_UPD_DECIDE = 4'd5;
    localparam step_t S_FLAG       = 4'd6;
    localparam step_t S_LK_START   = 4'd7;
    localparam step_t S_LK_LAST    = 4'd8;
    localparam step_t S_LK_MID     = 4'd9;
    localparam step_t S_LK_CMP     = 4'd10;

    // branch taken when the condition holds, alt otherwise
    typedef struct packed {
        op_t   op;
        jc_t   jc;
        step_t target;
        step_t alt;
    } ctl_word_t;

    function automatic ctl_word_t ctl_rom(input step_t s);
        ctl_word_t w;
        case (s)
            S_IDLE:       w = '{OP_ACCEPT,     JC_DISPATCH,   S_IDLE,       S_IDLE};
            S_INIT:       w = '{OP_INIT_REGS,  JC_ALWAYS,     S_FILL,       S_FILL};
            S_FILL:       w = '{OP_FILL,       JC_FILL_MORE,  S_FILL,       S_EMIT};
            S_EMIT:       w = '{OP_EMIT,       JC_OUT_READY,  S_IDLE,       S_EMIT};
            S_UPD_READ:   w = '{OP_UPD_READ,   JC_ALWAYS,     S_UPD_DECIDE, S_UPD_DECIDE};
            S_UPD_DECIDE: w = '{OP_UPD_DECIDE, JC_ALWAYS,     S_EMIT,       S_EMIT};
            S_FLAG:       w = '{OP_FLAG_CLR,   JC_ALWAYS,     S_EMIT,       S_EMIT};
            S_LK_START:   w = '{OP_LK_INIT,    JC_EMPTY,      S_EMIT,       S_LK_LAST};
            S_LK_LAST:    w = '{OP_LK_LAST,    JC_LAST_LOW,   S_EMIT,       S_LK_MID};
            S_LK_MID:     w = '{OP_LK_MID,     JC_RANGE_DONE, S_EMIT,       S_LK_CMP};
            S_LK_CMP:     w = '{OP_LK_CMP,     JC_HIT,        S_EMIT,       S_LK_MID};
            default:      w = '{OP_EMIT,       JC_ALWAYS,     S_IDLE,       S_IDLE};
        endcase
        return w;
    endfunction

    // first step of the routine for each item kind
    function automatic step_t entry_step(input logic [1:0] kind);
        step_t s;
        case (kind)
            KIND_INIT:   s = S_INIT;
            KIND_UPDATE: s = S_UPD_READ;
            KIND_LOOKUP: s = S_LK_START;
            KIND_FLAG:   s = S_FLAG;
            default:     s = S_IDLE;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

### hdl/bsts_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsts_table: row storage of the best size table
// One write port for size and construction data, one registered read port
// for sizes. Construction data is kept per row alongside the size.
// ----------------------------------------------------------------------------
module bsts_table #(
    parameter int DEPTH = bsts_pkg::TABLE_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [bsts_pkg::SIZE_W-1:0]   wr_size,
    input  wire logic [bsts_pkg::AUX_W-1:0]    wr_aux,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [bsts_pkg::SIZE_W-1:0]   rd_size
);
    import bsts_pkg::*;

    logic [SIZE_W-1:0] size_mem [DEPTH];
    logic [AUX_W-1:0]  aux_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            size_mem[wr_addr] <= wr_size;
            aux_mem[wr_addr]  <= wr_aux;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_size <= size_mem[rd_addr];
    end

endmodule
`default_nettype wire

### hdl/best_size_table_update_search_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// best_size_table_update_search_unit: capped best size table with search
// Keeps one best size and its construction per row, applies capped updates,
// answers lower-bound lookups and reports a sticky changed flag.
// ----------------------------------------------------------------------------
//
//  channel   direction  word         handshake
//  -------   ---------  -----------  -----------------------------------
//  in        input      bsts_in_t    in_valid / in_stall (stall driven here)
//  out       output     bsts_out_t   out_valid / out_stall (stall from sink)
//  cfg       input      64-bit data  cfg_we, cfg_index; no wait, no read-back
//
//  An init item loads the clamped entry count and refills every row. A lookup
//  stops without a search on an empty table or when the last row is below
//  the query; otherwise it runs a binary search over the rows in use.
//  The search pays one table read per step through the single read port.
//  Reset runs a fill pass over all TABLE_DEPTH rows; no word is taken until
//  it ends. Configuration writes are taken at any time.
//  A finished result sits in the output register; the next word may be
//  taken while it waits, and the sequencer holds in its emit step only if a
//  second result is ready before the first one leaves.
//
module best_size_table_update_search_unit #(
    parameter int TABLE_DEPTH = bsts_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [bsts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bsts_pkg::CFG_DATA_W-1:0]   cfg_data,
    // item input
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire bsts_pkg::bsts_in_t                in_data,
    // result output
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output bsts_pkg::bsts_out_t                    out_data
);
    import bsts_pkg::*;

    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int CW          = $clog2(TABLE_DEPTH + 1);   // holds the count itself
    localparam int IW          = CW + 1;                    // signed search bounds
    localparam int CMPW        = (CW > ROW_W) ? CW : ROW_W;
    localparam int RESET_COUNT = (TABLE_DEPTH < ENTRY_RESET) ? TABLE_DEPTH : ENTRY_RESET;

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0] size_cap_reg;
    logic [ROW_W-1:0]  entry_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cap_reg    <= '1;
            entry_count_reg <= ROW_W'(ENTRY_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIZE_CAP:    size_cap_reg    <= cfg_data;
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data[ROW_W-1:0];
                default:         ;   // drop writes to unknown indexes
            endcase
        end
    end

    // ---------------- sequencer and control state ----------------
    step_t           step_reg,      step_next;
    logic            has_item_reg,  has_item_next;
    logic            out_valid_reg, out_valid_next;
    logic [CW-1:0]   count_reg,     count_next;
    logic            flag_reg,      flag_next;
    logic [AW-1:0]   fill_cnt_reg,  fill_cnt_next;

    // ---------------- datapath registers ----------------
    bsts_in_t              item_reg,     item_next;
    bsts_out_t             res_reg,      res_next;
    bsts_out_t             out_data_reg, out_data_next;
    logic signed [IW-1:0]  low_reg,      low_next;
    logic signed [IW-1:0]  high_reg,     high_next;
    logic [AW-1:0]         mid_reg,      mid_next;

    // ---------------- table port ----------------
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [SIZE_W-1:0] wr_size;
    logic [AUX_W-1:0]  wr_aux;
    logic [AW-1:0]     rd_addr;
    logic [SIZE_W-1:0] rd_size;

    bsts_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_size (wr_size),
        .wr_aux  (wr_aux),
        .rd_addr (rd_addr),
        .rd_size (rd_size)
    );

    // ---------------- derived values ----------------
    ctl_word_t            ctl;
    logic                 in_accept;
    logic                 out_free;
    logic [CW-1:0]        entry_clamp;
    logic                 row_in_range;
    logic                 upd_take;
    logic                 upd_saturate;
    logic signed [IW-1:0] count_m1;
    logic signed [IW-1:0] span;
    logic signed [IW-1:0] mid_comb;
    logic signed [IW-1:0] mid_ext;
    logic                 range_done;
    logic                 hit;
    logic                 jump_cond;

    assign ctl       = ctl_rom(step_reg);
    assign in_stall  = (step_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // init loads entry_count clamped to the table depth
    assign entry_clamp = (CMPW'(entry_count_reg) > CMPW'(TABLE_DEPTH)) ?
                         CW'(TABLE_DEPTH) : CW'(entry_count_reg);

    // update: rd_size holds the current size of the addressed row
    assign row_in_range = CMPW'(item_reg.row) < CMPW'(count_reg);
    assign upd_take     = row_in_range && (item_reg.size_value > rd_size)
                          && (rd_size != size_cap_reg);
    assign upd_saturate = item_reg.size_value >= size_cap_reg;

    // search bounds: low in [0, count], high in [-1, count-1]
    assign count_m1   = $signed({1'b0, count_reg}) - $signed(IW'(1));
    assign span       = high_reg - low_reg;
    assign mid_comb   = low_reg + (span >>> 1);
    assign mid_ext    = $signed({1'b0, CW'(mid_reg)});
    assign range_done = low_reg > high_reg;
    assign hit        = rd_size == item_reg.size_value;

    always_comb
    begin
        case (ctl.jc)
            JC_ALWAYS:     jump_cond = 1'b1;
            JC_DISPATCH:   jump_cond = in_accept;
            JC_FILL_MORE:  jump_cond = fill_cnt_reg != AW'(TABLE_DEPTH - 1);
            JC_OUT_READY:  jump_cond = out_free || !has_item_reg;
            JC_EMPTY:      jump_cond = count_reg == '0;
            JC_LAST_LOW:   jump_cond = rd_size < item_reg.size_value;
            JC_RANGE_DONE: jump_cond = range_done;
            JC_HIT:        jump_cond = hit;
            default:       jump_cond = 1'b1;
        endcase
    end

    always_comb
    begin
        // sequencing
        if (ctl.jc == JC_DISPATCH)
            step_next = in_accept ? entry_step(in_data.kind) : ctl.alt;
        else
            step_next = jump_cond ? ctl.target : ctl.alt;

        // hold by default
        has_item_next  = has_item_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        fill_cnt_next  = fill_cnt_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;

        // identity row on the write port unless an update overrides it
        wr_en   = 1'b0;
        wr_addr = fill_cnt_reg;
        wr_size = SIZE_W'(fill_cnt_reg);
        wr_aux  = {CID_W'(0), PARAM_W'(fill_cnt_reg), {((PARAM_COUNT-1)*PARAM_W){1'b0}}};
        rd_addr = '0;

        // the sink took the word on the output register
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (ctl.op)
            OP_ACCEPT:
            begin
                if (in_accept)
                begin
                    item_next             = in_data;
                    has_item_next         = 1'b1;
                    res_next.found_index  = '0;
                    res_next.not_found    = 1'b0;
                    res_next.accepted     = 1'b0;
                    res_next.changed_flag = flag_reg;
                end
            end
            OP_INIT_REGS:
            begin
                count_next    = entry_clamp;
                flag_next     = 1'b0;
                fill_cnt_next = '0;
            end
            OP_FILL:
            begin
                wr_en         = 1'b1;
                fill_cnt_next = fill_cnt_reg + 1'b1;
            end
            OP_EMIT:
            begin
                // a fill after reset has no item and leaves no result
                if (has_item_reg && out_free)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    has_item_next  = 1'b0;
                end
            end
            OP_UPD_READ:
            begin
                rd_addr = AW'(item_reg.row);
            end
            OP_UPD_DECIDE:
            begin
                if (upd_take)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(item_reg.row);
                    wr_size = upd_saturate ? size_cap_reg : item_reg.size_value;
                    wr_aux  = {item_reg.construction_id, item_reg.param_a, item_reg.param_b,
                               item_reg.param_c, item_reg.param_d, item_reg.param_e};
                    // a capped size truncates the table after this row
                    if (upd_saturate)
                        count_next = CW'(item_reg.row) + 1'b1;
                    flag_next         = 1'b1;
                    res_next.accepted = 1'b1;
                end
            end
            OP_FLAG_CLR:
            begin
                flag_next = 1'b0;
            end
            OP_LK_INIT:
            begin
                low_next  = '0;
                high_next = count_m1;
                rd_addr   = AW'($unsigned(count_m1));
                if (count_reg == '0)
                    res_next.not_found = 1'b1;
            end
            OP_LK_LAST:
            begin
                if (rd_size < item_reg.size_value)
                    res_next.not_found = 1'b1;
            end
            OP_LK_MID:
            begin
                rd_addr = AW'($unsigned(mid_comb));
                if (range_done)
                    res_next.found_index = ROW_W'($unsigned(low_reg));
                else
                    mid_next = AW'($unsigned(mid_comb));
            end
            OP_LK_CMP:
            begin
                if (hit)
                    res_next.found_index = ROW_W'(mid_reg);
                else if (rd_size > item_reg.size_value)
                    high_next = mid_ext - $signed(IW'(1));
                else
                    low_next = mid_ext + $signed(IW'(1));
            end
            default:
            begin
            end
        endcase
    end

    // control state; reset starts the identity fill pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_FILL;
            has_item_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= CW'(RESET_COUNT);
            flag_reg      <= 1'b0;
            fill_cnt_reg  <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            has_item_reg  <= has_item_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            fill_cnt_reg  <= fill_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        low_reg      <= low_next;
        high_reg     <= high_next;
        mid_reg      <= mid_next;
    end

endmodule
`default_nettype wire
